// ===== hdl/vna_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex normal accumulator package
// Shared types, field widths, function codes and the saturating add used by
// the accumulator datapath.
// ----------------------------------------------------------------------------
package vna_pkg;

	localparam int VERTEX_COUNT_DEF = 256;

	localparam int COORD_W = 24;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int ACC_W   = 60;
	localparam int SUM_W   = ACC_W + 1;

	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_FACE  = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_CLEAR = 2'd3
	} func_t;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [CROSS_W-1:0] cross_t;
	typedef logic signed [ACC_W-1:0]   acc_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vtx_t;

	typedef struct packed {
		diff_t x;
		diff_t y;
		diff_t z;
	} diff_vec_t;

	typedef struct packed {
		cross_t x;
		cross_t y;
		cross_t z;
	} cross_vec_t;

	typedef struct packed {
		acc_t x;
		acc_t y;
		acc_t z;
	} acc_vec_t;

	// Operation on the accumulator store: read, add or zero.
	typedef struct packed {
		logic rd;
		logic add;
		logic zero;
	} acc_op_t;

	localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	function automatic acc_t sat_add(input acc_t acc, input cross_t d);
		logic signed [SUM_W-1:0] s;
		acc_t r;
		s = SUM_W'(acc) + SUM_W'(d);
		if (s[SUM_W-1] != s[SUM_W-2]) begin
			r = s[SUM_W-1] ? ACC_MIN : ACC_MAX;
		end else begin
			r = s[ACC_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== hdl/vna_cross_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross product unit
// One shared signed multiplier, stepped six times, forms n = b x a.
// ----------------------------------------------------------------------------
module vna_cross_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  vna_pkg::diff_vec_t     a,
	input  vna_pkg::diff_vec_t     b,
	output logic                   done,
	output vna_pkg::cross_vec_t    n
);
	import vna_pkg::*;

	localparam logic [2:0] LAST_STEP = 3'd6;
	localparam logic [2:0] STEP_NX   = 3'd2;
	localparam logic [2:0] STEP_NY   = 3'd4;

	logic       busy_q;
	logic [2:0] cnt_q;
	diff_t      mul_l;
	diff_t      mul_r;
	prod_t      prod_s1;
	prod_t      first_q;
	cross_t     diff;
	cross_vec_t n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 3'd1;
		end
	end

	// Even steps give the first product of a component, odd steps the second.
	always_comb begin
		case (cnt_q)
			3'd0: begin mul_l = b.y; mul_r = a.z; end
			3'd1: begin mul_l = b.z; mul_r = a.y; end
			3'd2: begin mul_l = b.z; mul_r = a.x; end
			3'd3: begin mul_l = b.x; mul_r = a.z; end
			3'd4: begin mul_l = b.x; mul_r = a.y; end
			default: begin mul_l = b.y; mul_r = a.x; end
		endcase
	end

	assign diff = CROSS_W'(first_q) - CROSS_W'(prod_s1);

	always_ff @(posedge clk) begin
		if (busy_q && cnt_q != LAST_STEP) begin
			prod_s1 <= mul_l * mul_r;
		end
		if (busy_q && cnt_q[0]) begin
			first_q <= prod_s1;
		end
		if (busy_q && cnt_q != 3'd0 && !cnt_q[0]) begin
			case (cnt_q)
				STEP_NX: n_q.x <= diff;
				STEP_NY: n_q.y <= diff;
				default: n_q.z <= diff;
			endcase
		end
	end

	assign done = busy_q && (cnt_q == LAST_STEP);
	assign n    = n_q;

endmodule

// ===== hdl/vna_accum_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Normal accumulator store
// One row of three saturating accumulators per vertex, read-modify-write.
// ----------------------------------------------------------------------------
module vna_accum_unit #(
	parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF,
	localparam int AW = $clog2(VERTEX_COUNT)
) (
	input  logic                  clk,
	input  vna_pkg::acc_op_t      op,
	input  logic [AW-1:0]         addr,
	input  vna_pkg::cross_vec_t   addend,
	output vna_pkg::acc_vec_t     rdata
);
	import vna_pkg::*;

	acc_vec_t mem [VERTEX_COUNT];
	acc_vec_t rdata_q;
	acc_vec_t sum;

	// The add step writes back to the row fetched by the preceding read step.
	always_comb begin
		sum.x = sat_add(rdata_q.x, addend.x);
		sum.y = sat_add(rdata_q.y, addend.y);
		sum.z = sat_add(rdata_q.z, addend.z);
	end

	always_ff @(posedge clk) begin
		if (op.zero) begin
			mem[addr] <= '0;
		end else if (op.add) begin
			mem[addr] <= sum;
		end
		if (op.rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/vertex_normal_accumulator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex normal accumulator core
// Builds unnormalised, area-weighted vertex normals from loaded vertices and
// faces, with saturating Q-format accumulators and a read-back channel.
// ----------------------------------------------------------------------------
// Items: a load item is written to the vertex store on acceptance. A read
// item passes through the read and emit states and waits in emit until the
// output register is free. A face item keeps the block busy through four
// vertex-store reads, the steps on the shared multiplier and six steps on the
// accumulator store port. A clear item, like the release of arst_n, sweeps
// the accumulator store to zero, one row per cycle; no item is taken meanwhile.
module vertex_normal_accumulator_core #(
	parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  logic [1:0]      func,
	input  logic [7:0]      index_a,
	input  logic [7:0]      index_b,
	input  logic [7:0]      index_c,
	input  vna_pkg::coord_t coord_x,
	input  vna_pkg::coord_t coord_y,
	input  vna_pkg::coord_t coord_z,
	output logic            result_valid,
	input  logic            result_stall,
	output logic [7:0]      read_vertex,
	output vna_pkg::acc_t   normal_x,
	output vna_pkg::acc_t   normal_y,
	output vna_pkg::acc_t   normal_z
);
	import vna_pkg::*;

	localparam int AW = $clog2(VERTEX_COUNT);
	localparam int IW = (AW > 8) ? AW : 8;
	localparam logic [2:0] FETCH_LAST = 3'd3;
	localparam logic [2:0] ACC_LAST   = 3'd5;

	// The sequencer walks one item at a time through these states. The
	// clearing sweep is also the state entered on reset.
	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_FETCH = 7'b0000100,
		S_CROSS = 7'b0001000,
		S_ACC   = 7'b0010000,
		S_READ  = 7'b0100000,
		S_EMIT  = 7'b1000000
	} state_t;

	function automatic logic [AW-1:0] to_addr(input logic [7:0] idx);
		logic [IW-1:0] w;
		w = IW'(idx);
		return w[AW-1:0];
	endfunction

	function automatic logic in_range(input logic [7:0] idx);
		return {24'd0, idx} < 32'(VERTEX_COUNT);
	endfunction

	function automatic diff_vec_t vsub(input vtx_t p, input vtx_t q);
		diff_vec_t d;
		d.x = DIFF_W'(p.x) - DIFF_W'(q.x);
		d.y = DIFF_W'(p.y) - DIFF_W'(q.y);
		d.z = DIFF_W'(p.z) - DIFF_W'(q.z);
		return d;
	endfunction

	state_t        state_q;
	logic [2:0]    step_q;
	logic [AW-1:0] clr_addr_q;
	logic [AW-1:0] c0_q;
	logic [AW-1:0] c1_q;
	logic [AW-1:0] c2_q;
	logic [7:0]    read_idx_q;
	logic          read_ok_q;

	// Vertex positions: written by load items, read once per corner of a face.
	vtx_t          vmem [VERTEX_COUNT];
	vtx_t          vrd_q;
	vtx_t          v1_q;
	logic [AW-1:0] vaddr;
	diff_vec_t     a_q;
	diff_vec_t     b_q;

	logic          cross_start;
	logic          cross_done;
	cross_vec_t    cross_n;

	acc_op_t       acc_op;
	logic [AW-1:0] acc_addr;
	logic [AW-1:0] acc_corner;
	acc_vec_t      acc_rdata;

	logic          accept;
	logic          out_free;
	logic          face_ok;

	logic          result_valid_q;
	logic [7:0]    read_vertex_q;
	acc_t          normal_x_q;
	acc_t          normal_y_q;
	acc_t          normal_z_q;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != S_IDLE);
	// The output register can take a new result when it is empty or its
	// current item leaves at this edge.
	assign out_free   = !result_valid_q || !result_stall;
	assign face_ok    = in_range(index_a) && in_range(index_b) && in_range(index_c);

	// Sequencer. A face that names a vertex outside the store does nothing,
	// so it never leaves idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			step_q     <= '0;
			clr_addr_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(VERTEX_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (func)
							FUNC_FACE: begin
								if (face_ok) begin
									state_q <= S_FETCH;
									step_q  <= '0;
								end
							end
							FUNC_READ: begin
								state_q <= S_READ;
							end
							FUNC_CLEAR: begin
								state_q    <= S_CLEAR;
								clr_addr_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_FETCH: begin
					step_q <= step_q + 3'd1;
					if (step_q == FETCH_LAST) begin
						state_q <= S_CROSS;
					end
				end
				S_CROSS: begin
					if (cross_done) begin
						state_q <= S_ACC;
						step_q  <= '0;
					end
				end
				S_ACC: begin
					step_q <= step_q + 3'd1;
					if (step_q == ACC_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result valid: set as a read item's result is loaded, cleared once the
	// receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// Corner addresses, captured on acceptance; corner zero doubles as the
	// address of a read item.
	always_ff @(posedge clk) begin
		if (accept) begin
			c0_q       <= to_addr(index_a);
			c1_q       <= to_addr(index_b);
			c2_q       <= to_addr(index_c);
			read_idx_q <= index_a;
			read_ok_q  <= in_range(index_a);
		end
	end

	always_comb begin
		case (step_q[1:0])
			2'd0:    vaddr = c0_q;
			2'd1:    vaddr = c1_q;
			default: vaddr = c2_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && func == FUNC_LOAD && in_range(index_a)) begin
			vmem[to_addr(index_a)] <= vtx_t'{coord_x, coord_y, coord_z};
		end
		vrd_q <= vmem[vaddr];
	end

	// Read data is registered, so the first corner lands at step one, and
	// the second and third give a and b at steps two and three.
	always_ff @(posedge clk) begin
		if (state_q == S_FETCH) begin
			case (step_q)
				3'd1:    v1_q <= vrd_q;
				3'd2:    a_q  <= vsub(vrd_q, v1_q);
				3'd3:    b_q  <= vsub(vrd_q, v1_q);
				default: begin
				end
			endcase
		end
	end

	assign cross_start = (state_q == S_FETCH) && (step_q == FETCH_LAST);

	vna_cross_unit u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cross_start),
		.a      (a_q),
		.b      (b_q),
		.done   (cross_done),
		.n      (cross_n)
	);

	// Accumulation alternates a read step and an add step for each corner.
	always_comb begin
		case (step_q[2:1])
			2'd0:    acc_corner = c0_q;
			2'd1:    acc_corner = c1_q;
			default: acc_corner = c2_q;
		endcase
	end

	always_comb begin
		acc_op.rd   = 1'b0;
		acc_op.add  = 1'b0;
		acc_op.zero = 1'b0;
		acc_addr    = c0_q;
		if (state_q == S_CLEAR) begin
			acc_op.zero = 1'b1;
			acc_addr    = clr_addr_q;
		end else if (state_q == S_ACC) begin
			acc_op.rd  = !step_q[0];
			acc_op.add = step_q[0];
			acc_addr   = acc_corner;
		end else if (state_q == S_READ) begin
			acc_op.rd = 1'b1;
		end
	end

	vna_accum_unit #(
		.VERTEX_COUNT (VERTEX_COUNT)
	) u_accum (
		.clk    (clk),
		.op     (acc_op),
		.addr   (acc_addr),
		.addend (cross_n),
		.rdata  (acc_rdata)
	);

	// Result register. An index beyond the store reads back as zero normals.
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			read_vertex_q <= read_idx_q;
			normal_x_q    <= read_ok_q ? acc_rdata.x : '0;
			normal_y_q    <= read_ok_q ? acc_rdata.y : '0;
			normal_z_q    <= read_ok_q ? acc_rdata.z : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign read_vertex  = read_vertex_q;
	assign normal_x     = normal_x_q;
	assign normal_y     = normal_y_q;
	assign normal_z     = normal_z_q;

endmodule

// ===== hdl/vna_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex normal accumulator port checker
// Watches the top level's ports and flags behaviour the block must not show.
// ----------------------------------------------------------------------------
module vna_checker #(
	parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF
) (
	input logic            clk,
	input logic            arst_n,
	input logic            item_valid,
	input logic            item_stall,
	input logic [1:0]      func,
	input logic            result_valid,
	input logic            result_stall,
	input logic [7:0]      read_vertex,
	input vna_pkg::acc_t   normal_x,
	input vna_pkg::acc_t   normal_y,
	input vna_pkg::acc_t   normal_z
);
	import vna_pkg::*;

	logic accept;
	assign accept = item_valid && !item_stall;

	// A stalled result holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(read_vertex)
			&& $stable(normal_x) && $stable(normal_y) && $stable(normal_z))
		else $error("stalled result changed");

	// A read item keeps the block busy until its result is formed.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && func == FUNC_READ |=> item_stall)
		else $error("read item did not make the block busy");

	// A clear item starts the sweep of the accumulator store.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && func == FUNC_CLEAR |=> item_stall)
		else $error("clear item did not make the block busy");

	// A new result only appears at the end of a busy read.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result appeared while idle");

	// A vertex outside the store reads back as a zero normal.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && ({24'd0, read_vertex} >= 32'(VERTEX_COUNT))
			|-> normal_x == '0 && normal_y == '0 && normal_z == '0)
		else $error("out-of-range read returned a non-zero normal");

endmodule

bind vertex_normal_accumulator_core vna_checker #(
	.VERTEX_COUNT (VERTEX_COUNT)
) u_vna_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.func         (func),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.read_vertex  (read_vertex),
	.normal_x     (normal_x),
	.normal_y     (normal_y),
	.normal_z     (normal_z)
);
